// ----- hw/rtl/tw_pkg.sv -----
// Shared constants, codes and types of the two-way tile window cache.
// No dependencies; every other file of the block but tw_if imports this package.
package tw_pkg;

    localparam int WIN_COLS    = 64;
    localparam int WIN_ROWS    = 32;
    localparam int NUM_SLOTS   = 2;
    localparam int WAYS        = 2;
    localparam int IMAGE_TILES = 131072;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 128;

    localparam int COL_W   = $clog2(WIN_COLS);
    localparam int ROW_W   = $clog2(WIN_ROWS);
    localparam int SLOT_W  = 1;
    localparam int WAY_W   = 1;
    localparam int LIN_W   = $clog2(IMAGE_TILES);
    localparam int IMG_AW  = SLOT_W + LIN_W;
    localparam int WIN_AW  = SLOT_W + WAY_W + ROW_W + COL_W;
    localparam int META_W  = SLOT_W + WAY_W;
    localparam int XW      = 11;
    localparam int YW      = 7;
    localparam int PADDR_W = 4;

    localparam logic [15:0] OUTSIDE_TILE = 16'hFFFF;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_INVAL = 2'd2;

    localparam logic [2:0] OC_HIT     = 3'd0;
    localparam logic [2:0] OC_SWAP    = 3'd1;
    localparam logic [2:0] OC_REFILL  = 3'd2;
    localparam logic [2:0] OC_OUTSIDE = 3'd3;
    localparam logic [2:0] OC_WRITTEN = 3'd4;
    localparam logic [2:0] OC_IGNORED = 3'd5;
    localparam logic [2:0] OC_INVAL   = 3'd6;

    localparam logic [1:0] REG_W0 = 2'd0;
    localparam logic [1:0] REG_H0 = 2'd1;
    localparam logic [1:0] REG_W1 = 2'd2;
    localparam logic [1:0] REG_H1 = 2'd3;

    typedef struct packed {
        logic              img_we;
        logic [IMG_AW-1:0] img_waddr;
        logic [15:0]       img_wdata;
        logic [IMG_AW-1:0] img_raddr;
        logic              win_we;
        logic [WIN_AW-1:0] win_waddr;
        logic [15:0]       win_wdata;
        logic [WIN_AW-1:0] win_raddr;
    } t_mem_req;

    typedef struct packed {
        logic [15:0]   tile_out;
        logic [2:0]    outcome;
        logic          way_used;
        logic [XW-1:0] origin_x;
        logic [YW-1:0] origin_y;
    } t_result;

    // True when a valid window at (ox, oy) covers tile (x, y).
    function automatic logic win_has(input logic vld, input logic [XW-1:0] ox,
                                     input logic [YW-1:0] oy, input logic [XW-1:0] x,
                                     input logic [YW-1:0] y);
        logic hx;
        logic hy;
        hx = (x >= ox) && ({1'b0, x} < ({1'b0, ox} + 12'(WIN_COLS)));
        hy = (y >= oy) && ({1'b0, y} < ({1'b0, oy} + 8'(WIN_ROWS)));
        return vld && hx && hy;
    endfunction

endpackage

// ----- hw/rtl/tw_if.sv -----
// Valid/ready channel interfaces of the tile window cache.
// Depends on tw_pkg for nothing but shares its field widths.
interface tw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic        slot_sel;
    logic signed [12:0] tile_x;
    logic signed [12:0] tile_y;
    logic [15:0] tile_value;

    modport source (output valid, action, slot_sel, tile_x, tile_y, tile_value, input ready);
    modport sink (input valid, action, slot_sel, tile_x, tile_y, tile_value, output ready);
endinterface

interface tw_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] tile_out;
    logic [2:0]  outcome;
    logic        way_used;
    logic [10:0] origin_x;
    logic [6:0]  origin_y;

    modport source (output valid, tile_out, outcome, way_used, origin_x, origin_y, input ready);
    modport sink (input valid, tile_out, outcome, way_used, origin_x, origin_y, output ready);
endinterface

// ----- hw/rtl/tw_store.sv -----
// Layer image and window tile memories, each one write and one registered read port.
// Depends on tw_pkg for the address widths and the request struct.
module tw_store
    import tw_pkg::*;
(
    input  logic        i_clk,
    input  t_mem_req    i_req,
    output logic [15:0] o_img_rdata,
    output logic [15:0] o_win_rdata
);

    localparam int IMG_DEPTH = 2 ** IMG_AW;
    localparam int WIN_DEPTH = 2 ** WIN_AW;

    logic [15:0] r_img [IMG_DEPTH];
    logic [15:0] r_win [WIN_DEPTH];
    logic [15:0] r_img_rdata;
    logic [15:0] r_win_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.img_we) begin
            r_img[i_req.img_waddr] <= i_req.img_wdata;
        end
        r_img_rdata <= r_img[i_req.img_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.win_we) begin
            r_win[i_req.win_waddr] <= i_req.win_wdata;
        end
        r_win_rdata <= r_win[i_req.win_raddr];
    end

    assign o_img_rdata = r_img_rdata;
    assign o_win_rdata = r_win_rdata;

endmodule

// ----- hw/rtl/two_way_tile_window_cache.sv -----
// Top level of the two-way tile window cache: sequencer, window tags and APB registers.
// Depends on tw_pkg, tw_if (channel interfaces) and tw_store (memories).
//
// Usage: requests arrive on i_in as transfers of action, slot, tile column/row
// and a write value; every request except the unused action code produces one
// result transfer on o_out. The block handles one request at a time and takes
// a new one while a finished result still waits in the output register.
// A refill miss copies the window one image tile per cycle through the image
// read port into the window memory.
// The copy loop on the image memory's single read port sets the miss cost;
// the registered window memory read sets the hit cost.
// Reset clears the window tags, the active way of each slot and the size
// registers (width 1024, height 128); the memories are not cleared and need
// no clearing pass. A stalled receiver holds the result in the output
// register; the sequencer then waits in its last state until it is taken.
// Writing a size register invalidates that slot's windows.
module two_way_tile_window_cache
    import tw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    tw_in_if.sink              i_in,
    tw_out_if.source           o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_MUL, S_COPY, S_DRAIN, S_TRD, S_TWAIT, S_WIMG, S_WWIN, S_DONE
    } t_state;

    t_state r_state;

    // Size registers and window tags.
    logic [11:0]   r_width  [NUM_SLOTS];
    logic [7:0]    r_height [NUM_SLOTS];
    logic          r_valid  [NUM_SLOTS*WAYS];
    logic [XW-1:0] r_ox     [NUM_SLOTS*WAYS];
    logic [YW-1:0] r_oy     [NUM_SLOTS*WAYS];
    logic          r_active [NUM_SLOTS];

    // Latched request.
    logic [1:0]  r_act;
    logic        r_slot;
    logic [12:0] r_x;
    logic [12:0] r_y;
    logic [15:0] r_val;

    // Work registers.
    logic              r_is_read;
    logic [META_W-1:0] r_wi;
    logic [COL_W-1:0]  r_dx;
    logic [ROW_W-1:0]  r_dy;
    logic [COL_W-1:0]  r_clast;
    logic [ROW_W-1:0]  r_rlast;
    logic [11:0]       r_w;
    logic [YW-1:0]     r_ma;
    logic [XW-1:0]     r_mb;
    logic [LIN_W-1:0]  r_row_src;
    logic [COL_W-1:0]  r_c;
    logic [ROW_W-1:0]  r_r;
    logic              r_cp_pend;
    logic [WIN_AW-1:0] r_cp_dst;
    logic              r_whas [WAYS];
    logic [COL_W-1:0]  r_wdx  [WAYS];
    logic [ROW_W-1:0]  r_wdy  [WAYS];
    t_result           r_res;
    t_result           r_out;
    logic              r_ov;

    t_mem_req    mem_req;
    logic [15:0] img_rdata;
    logic [15:0] win_rdata;

    tw_store u_store (
        .i_clk       (i_clk),
        .i_req       (mem_req),
        .o_img_rdata (img_rdata),
        .o_win_rdata (win_rdata)
    );

    // Request decode, from the latched request and the tags.
    logic [11:0]         eff_w;
    logic [7:0]          eff_h;
    logic                in_layer;
    logic [XW-1:0]       x11;
    logic [YW-1:0]       y7;
    logic                way_a;
    logic [META_W-1:0]   ia;
    logic [META_W-1:0]   io;
    logic                has_a;
    logic                has_o;
    logic                has0;
    logic                has1;
    logic signed [13:0]  sx;
    logic signed [13:0]  limx;
    logic signed [13:0]  cx;
    logic signed [9:0]   sy;
    logic signed [9:0]   limy;
    logic signed [9:0]   cy;
    logic [XW-1:0]       wx;
    logic [YW-1:0]       wy;
    logic [11:0]         cw;
    logic [7:0]          rh;
    logic [COL_W-1:0]    clast;
    logic [ROW_W-1:0]    rlast;
    logic [XW-1:0]       tox;
    logic [YW-1:0]       toy;
    logic [YW+12:0]      mul_sum;
    logic                cfg_wr;

    always_comb begin
        eff_w  = (r_width[r_slot] > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : r_width[r_slot];
        eff_h  = (r_height[r_slot] > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : r_height[r_slot];
        in_layer = !r_x[12] && !r_y[12] && (r_x[11:0] < eff_w)
                   && ({4'b0, r_y[7:0]} < {4'b0, eff_h}) && (r_y[11:8] == 4'd0);
        x11    = r_x[XW-1:0];
        y7     = r_y[YW-1:0];
        way_a  = r_active[r_slot];
        ia     = {r_slot, way_a};
        io     = {r_slot, ~way_a};
        has_a  = win_has(r_valid[ia], r_ox[ia], r_oy[ia], x11, y7);
        has_o  = win_has(r_valid[io], r_ox[io], r_oy[io], x11, y7);
        has0   = win_has(r_valid[{r_slot, 1'b0}], r_ox[{r_slot, 1'b0}],
                         r_oy[{r_slot, 1'b0}], x11, y7);
        has1   = win_has(r_valid[{r_slot, 1'b1}], r_ox[{r_slot, 1'b1}],
                         r_oy[{r_slot, 1'b1}], x11, y7);

        // Refill origin, clamped into the layer.
        sx   = $signed({3'b0, x11}) - $signed(14'(WIN_COLS / 4));
        limx = $signed({2'b0, eff_w}) - $signed(14'(WIN_COLS));
        cx   = (sx > limx) ? limx : sx;
        cx   = (cx < 14'sd0) ? 14'sd0 : cx;
        wx   = cx[XW-1:0];
        sy   = $signed({3'b0, y7}) - $signed(10'(WIN_ROWS / 4));
        limy = $signed({2'b0, eff_h}) - $signed(10'(WIN_ROWS));
        cy   = (sy > limy) ? limy : sy;
        cy   = (cy < 10'sd0) ? 10'sd0 : cy;
        wy   = cy[YW-1:0];
        cw    = eff_w - {1'b0, wx};
        rh    = eff_h - {1'b0, wy};
        clast = (cw >= 12'(WIN_COLS)) ? COL_W'(WIN_COLS - 1) : COL_W'(cw - 12'd1);
        rlast = (rh >= 8'(WIN_ROWS)) ? ROW_W'(WIN_ROWS - 1) : ROW_W'(rh - 8'd1);

        // Origin of the window that will serve a read.
        if (has_a) begin
            tox = r_ox[ia];
            toy = r_oy[ia];
        end else if (has_o) begin
            tox = r_ox[io];
            toy = r_oy[io];
        end else begin
            tox = wx;
            toy = wy;
        end

        mul_sum = (YW+13)'(r_ma) * (YW+13)'(r_w) + (YW+13)'(r_mb);
        cfg_wr  = psel && penable && pwrite && pready;
    end

    // Memory port steering.
    always_comb begin
        mem_req           = '0;
        mem_req.img_raddr = {r_slot, LIN_W'(r_row_src + LIN_W'(r_c))};
        mem_req.img_waddr = {r_slot, r_row_src};
        mem_req.img_wdata = r_val;
        mem_req.img_we    = (r_state == S_WIMG);
        mem_req.win_raddr = {r_wi, r_dy, r_dx};
        mem_req.win_wdata = r_val;
        if (r_cp_pend) begin
            mem_req.win_we    = 1'b1;
            mem_req.win_waddr = r_cp_dst;
            mem_req.win_wdata = img_rdata;
        end else if (r_state == S_WIMG) begin
            mem_req.win_we    = r_whas[0];
            mem_req.win_waddr = {r_slot, 1'b0, r_wdy[0], r_wdx[0]};
        end else if (r_state == S_WWIN) begin
            mem_req.win_we    = r_whas[1];
            mem_req.win_waddr = {r_slot, 1'b1, r_wdy[1], r_wdx[1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ov      <= 1'b0;
            r_cp_pend <= 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_width[s]  <= 12'd1024;
                r_height[s] <= 8'd128;
                r_active[s] <= 1'b0;
            end
            for (int k = 0; k < NUM_SLOTS*WAYS; k++) begin
                r_valid[k] <= 1'b0;
                r_ox[k]    <= '0;
                r_oy[k]    <= '0;
            end
        end else begin
            r_cp_pend <= (r_state == S_COPY);
            // The output register is refilled from the final state, else it
            // empties once its transfer completes.
            if ((r_state == S_DONE) && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_ov <= 1'b0;
            end

            // Register writes must come only while idle (the user's duty, not enforced here); they rebind the slot.
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_W0: r_width[0]  <= pwdata[11:0];
                    REG_H0: r_height[0] <= pwdata[7:0];
                    REG_W1: r_width[1]  <= pwdata[11:0];
                    REG_H1: r_height[1] <= pwdata[7:0];
                    default: ;
                endcase
                r_active[paddr[3]] <= 1'b0;
                for (int k = 0; k < WAYS; k++) begin
                    r_valid[{paddr[3], 1'(k)}] <= 1'b0;
                    r_ox[{paddr[3], 1'(k)}]    <= '0;
                    r_oy[{paddr[3], 1'(k)}]    <= '0;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_act   <= i_in.action;
                        r_slot  <= i_in.slot_sel;
                        r_x     <= i_in.tile_x;
                        r_y     <= i_in.tile_y;
                        r_val   <= i_in.tile_value;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_w            <= eff_w;
                    r_dx           <= COL_W'(x11 - tox);
                    r_dy           <= ROW_W'(y7 - toy);
                    r_clast        <= clast;
                    r_rlast        <= rlast;
                    r_whas[0]      <= has0;
                    r_whas[1]      <= has1;
                    r_wdx[0]       <= COL_W'(x11 - r_ox[{r_slot, 1'b0}]);
                    r_wdy[0]       <= ROW_W'(y7 - r_oy[{r_slot, 1'b0}]);
                    r_wdx[1]       <= COL_W'(x11 - r_ox[{r_slot, 1'b1}]);
                    r_wdy[1]       <= ROW_W'(y7 - r_oy[{r_slot, 1'b1}]);
                    case (r_act)
                        ACT_READ: begin
                            r_is_read <= 1'b1;
                            if (!in_layer) begin
                                r_res   <= '{tile_out: OUTSIDE_TILE, outcome: OC_OUTSIDE,
                                             way_used: way_a, origin_x: '0, origin_y: '0};
                                r_state <= S_DONE;
                            end else if (has_a) begin
                                r_wi    <= ia;
                                r_res   <= '{tile_out: '0, outcome: OC_HIT,
                                             way_used: way_a, origin_x: tox, origin_y: toy};
                                r_state <= S_TRD;
                            end else if (has_o) begin
                                r_wi             <= io;
                                r_active[r_slot] <= ~way_a;
                                r_res            <= '{tile_out: '0, outcome: OC_SWAP,
                                                      way_used: ~way_a, origin_x: tox,
                                                      origin_y: toy};
                                r_state          <= S_TRD;
                            end else begin
                                r_wi             <= io;
                                r_active[r_slot] <= ~way_a;
                                r_valid[io]      <= 1'b1;
                                r_ox[io]         <= wx;
                                r_oy[io]         <= wy;
                                r_ma             <= wy;
                                r_mb             <= wx;
                                r_res            <= '{tile_out: '0, outcome: OC_REFILL,
                                                      way_used: ~way_a, origin_x: tox,
                                                      origin_y: toy};
                                r_state          <= S_MUL;
                            end
                        end
                        ACT_WRITE: begin
                            r_is_read <= 1'b0;
                            if (!in_layer) begin
                                r_res   <= '{tile_out: '0, outcome: OC_IGNORED,
                                             way_used: way_a, origin_x: '0, origin_y: '0};
                                r_state <= S_DONE;
                            end else begin
                                r_ma    <= y7;
                                r_mb    <= x11;
                                r_res   <= '{tile_out: '0, outcome: OC_WRITTEN,
                                             way_used: way_a, origin_x: '0, origin_y: '0};
                                r_state <= S_MUL;
                            end
                        end
                        ACT_INVAL: begin
                            r_is_read        <= 1'b0;
                            r_active[r_slot] <= 1'b0;
                            for (int k = 0; k < WAYS; k++) begin
                                r_valid[{r_slot, 1'(k)}] <= 1'b0;
                                r_ox[{r_slot, 1'(k)}]    <= '0;
                                r_oy[{r_slot, 1'(k)}]    <= '0;
                            end
                            r_res   <= '{tile_out: '0, outcome: OC_INVAL,
                                         way_used: 1'b0, origin_x: '0, origin_y: '0};
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_MUL: begin
                    r_row_src <= mul_sum[LIN_W-1:0];
                    r_c       <= '0;
                    r_r       <= '0;
                    r_state   <= r_is_read ? S_COPY : S_WIMG;
                end
                S_COPY: begin
                    r_cp_dst <= {r_wi, r_r, r_c};
                    if (r_c == r_clast) begin
                        r_c       <= '0;
                        r_row_src <= LIN_W'(r_row_src + LIN_W'(r_w));
                        if (r_r == r_rlast) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_r <= r_r + ROW_W'(1);
                        end
                    end else begin
                        r_c <= r_c + COL_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_TRD;
                end
                S_TRD: begin
                    r_state <= S_TWAIT;
                end
                S_TWAIT: begin
                    r_res.tile_out <= win_rdata;
                    r_state        <= S_DONE;
                end
                S_WIMG: begin
                    r_state <= S_WWIN;
                end
                S_WWIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ov || o_out.ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ov;
    assign o_out.tile_out = r_out.tile_out;
    assign o_out.outcome  = r_out.outcome;
    assign o_out.way_used = r_out.way_used;
    assign o_out.origin_x = r_out.origin_x;
    assign o_out.origin_y = r_out.origin_y;

    assign pready = 1'b1;
    always_comb begin
        case (paddr[3:2])
            REG_W0:  prdata = {20'b0, r_width[0]};
            REG_H0:  prdata = {24'b0, r_height[0]};
            REG_W1:  prdata = {20'b0, r_width[1]};
            REG_H1:  prdata = {24'b0, r_height[1]};
            default: prdata = '0;
        endcase
    end

`ifndef SYNTHESIS
    // An accepted request is always decoded in the next cycle.
    a_accept_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_DEC))
        else $error("accepted request not decoded");

    // The window being read has its tag set.
    a_read_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRD) |-> r_valid[r_wi])
        else $error("read from an empty window");

    // A new result is loaded only from the final state.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside the final state");

    // Copy writes never collide with write-path window updates.
    a_cp_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_pend |-> ((r_state == S_COPY) || (r_state == S_DRAIN)))
        else $error("copy write outside the refill");
`endif

endmodule

// ----- dv/tb_two_way_tile_window_cache.sv -----
// Self-checking testbench of the two-way tile window cache.
// Depends on tw_pkg, tw_if and the block two_way_tile_window_cache in hw/rtl.
`timescale 1ns / 1ps

module tb_two_way_tile_window_cache;
    import tw_pkg::*;

    // One request as it travels on the input channel.
    typedef struct {
        logic [1:0]         act;
        logic               slot;
        logic signed [12:0] x;
        logic signed [12:0] y;
        logic [15:0]        val;
    } t_req;

    // One row of the directed table; the expected result is typed in only
    // where it is obvious, else the window model below supplies it.
    typedef struct {
        t_req    req;
        bit      typed;
        t_result res;
    } t_row;

    localparam int WIN_TILES = WIN_COLS * WIN_ROWS;
    localparam int CYCLE_LIMIT = 10000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    tw_in_if  req_ch ();
    tw_out_if res_ch ();

    two_way_tile_window_cache dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Window model state: per slot image, window contents and tags.
    logic [15:0] image_mem [NUM_SLOTS][IMAGE_TILES];
    logic [15:0] win_mem [NUM_SLOTS*WAYS][WIN_TILES];
    int          win_ox [NUM_SLOTS*WAYS];
    int          win_oy [NUM_SLOTS*WAYS];
    bit          win_vld [NUM_SLOTS*WAYS];
    bit          act_way [NUM_SLOTS];
    logic [11:0] size_w [NUM_SLOTS];
    logic [7:0]  size_h [NUM_SLOTS];

    t_result pending_results[$];
    int      fail_cnt = 0;
    int      cycle_cnt = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    function automatic int layer_w(input bit s);
        return (size_w[s] > MAX_WIDTH) ? MAX_WIDTH : int'(size_w[s]);
    endfunction

    function automatic int layer_h(input bit s);
        return (size_h[s] > MAX_HEIGHT) ? MAX_HEIGHT : int'(size_h[s]);
    endfunction

    function automatic int lin_index(input int x, input int y, input int w);
        return (y * w + x) % IMAGE_TILES;
    endfunction

    function automatic bit covers(input int wi, input int x, input int y);
        return win_vld[wi] && x >= win_ox[wi] && x < win_ox[wi] + WIN_COLS
            && y >= win_oy[wi] && y < win_oy[wi] + WIN_ROWS;
    endfunction

    function automatic bit in_layer(input t_req r);
        return r.x >= 0 && r.y >= 0 && r.x < layer_w(r.slot) && r.y < layer_h(r.slot);
    endfunction

    // Origin and extent of the window a miss at (x, y) loads, clamped into the layer.
    function automatic void refill_span(input bit s, input int x, input int y,
                                        output int wx, output int wy,
                                        output int cols, output int rlast);
        int w;
        int h;
        w = layer_w(s);
        h = layer_h(s);
        wx = x - WIN_COLS / 4;
        wy = y - WIN_ROWS / 4;
        if (wx > w - WIN_COLS) wx = w - WIN_COLS;
        if (wy > h - WIN_ROWS) wy = h - WIN_ROWS;
        if (wx < 0) wx = 0;
        if (wy < 0) wy = 0;
        cols = (w - wx > WIN_COLS) ? WIN_COLS : w - wx;
        rlast = (wy + WIN_ROWS > h) ? h : wy + WIN_ROWS;
    endfunction

    function automatic void drop_windows(input bit s);
        for (int k = 0; k < WAYS; k++) begin
            win_vld[s*WAYS+k] = 1'b0;
            win_ox[s*WAYS+k] = 0;
            win_oy[s*WAYS+k] = 0;
        end
        act_way[s] = 1'b0;
    endfunction

    // Advances the window model by one request; returns 0 when no result follows.
    function automatic bit cache_step(input t_req r, output t_result res);
        int  x;
        int  y;
        int  w;
        int  wi;
        int  wx;
        int  wy;
        int  cols;
        int  rlast;
        bit  a;
        x = r.x;
        y = r.y;
        w = layer_w(r.slot);
        res = '0;
        if (r.act == 2'd3)
            return 1'b0;
        if (r.act == ACT_READ) begin
            if (!in_layer(r)) begin
                res.tile_out = OUTSIDE_TILE;
                res.outcome = OC_OUTSIDE;
            end else begin
                a = act_way[r.slot];
                if (covers(r.slot*WAYS+a, x, y)) begin
                    res.outcome = OC_HIT;
                end else if (covers(r.slot*WAYS+(a^1'b1), x, y)) begin
                    a = a ^ 1'b1;
                    res.outcome = OC_SWAP;
                end else begin
                    a = a ^ 1'b1;
                    wi = r.slot*WAYS + a;
                    refill_span(r.slot, x, y, wx, wy, cols, rlast);
                    for (int row = wy; row < rlast; row++)
                        for (int c = 0; c < cols; c++)
                            win_mem[wi][(row-wy)*WIN_COLS+c] =
                                image_mem[r.slot][lin_index(wx+c, row, w)];
                    win_ox[wi] = wx;
                    win_oy[wi] = wy;
                    win_vld[wi] = 1'b1;
                    res.outcome = OC_REFILL;
                end
                act_way[r.slot] = a;
                wi = r.slot*WAYS + a;
                res.tile_out = win_mem[wi][(y-win_oy[wi])*WIN_COLS + (x-win_ox[wi])];
                res.origin_x = XW'(win_ox[wi]);
                res.origin_y = YW'(win_oy[wi]);
            end
        end else if (r.act == ACT_WRITE) begin
            if (!in_layer(r)) begin
                res.outcome = OC_IGNORED;
            end else begin
                image_mem[r.slot][lin_index(x, y, w)] = r.val;
                for (int k = 0; k < WAYS; k++) begin
                    wi = r.slot*WAYS + k;
                    if (covers(wi, x, y))
                        win_mem[wi][(y-win_oy[wi])*WIN_COLS + (x-win_ox[wi])] = r.val;
                end
                res.outcome = OC_WRITTEN;
            end
        end else begin
            drop_windows(r.slot);
            res.outcome = OC_INVAL;
        end
        res.way_used = act_way[r.slot];
        return 1'b1;
    endfunction

    // Sender side. valid is left high after a transfer; it only drops when
    // the next request is held back, so it never toggles within one step.
    task automatic send_req(input t_req r, input bit typed, input t_result typed_res);
        t_result res;
        if (cache_step(r, res))
            pending_results.push_back(typed ? typed_res : res);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.action <= r.act;
        req_ch.slot_sel <= r.slot;
        req_ch.tile_x <= r.x;
        req_ch.tile_y <= r.y;
        req_ch.tile_value <= r.val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Size registers are written only with the block idle. An unused action
    // code leaves no result behind, so a short pause covers its last cycles.
    task automatic write_size(input logic [1:0] idx, input logic [31:0] value);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_W0: size_w[0] = value[11:0];
            REG_H0: size_h[0] = value[7:0];
            REG_W1: size_w[1] = value[11:0];
            default: size_h[1] = value[7:0];
        endcase
        drop_windows(idx[1]);
    endtask

    task automatic set_sizes(input int w0, input int h0, input int w1, input int h1);
        write_size(REG_W0, w0);
        write_size(REG_H0, h0);
        write_size(REG_W1, w1);
        write_size(REG_H1, h1);
    endtask

    // Random request with a mix weighted toward reads that land inside the
    // layer, near the previous read so that hits and swaps dominate. Big
    // layers are read in a corner so that refills stay affordable.
    task automatic random_req(inout int near_x, inout int near_y, inout bit near_s);
        t_req r;
        int   pick;
        int   span_x;
        int   span_y;
        r.slot = ($urandom_range(3) == 0) ? ~near_s : near_s;
        span_x = layer_w(r.slot);
        span_y = layer_h(r.slot);
        if (span_x * span_y > 4096) begin
            span_x = (span_x > 96) ? 96 : span_x;
            span_y = (span_y > 48) ? 48 : span_y;
        end
        r.val = 16'($urandom);
        r.x = 13'($urandom);
        r.y = 13'($urandom);
        pick = $urandom_range(99);
        if (pick < 3) begin
            r.act = 2'd3;
        end else if (pick < 8) begin
            r.act = ACT_INVAL;
        end else if (pick < 16) begin
            r.act = $urandom_range(1) ? ACT_WRITE : ACT_READ;
        end else begin
            r.act = (pick < 32) ? ACT_WRITE : ACT_READ;
            if (span_x > 0 && span_y > 0) begin
                if (pick >= 60 && r.slot == near_s) begin
                    r.x = 13'(near_x + $urandom_range(80) - 40);
                    r.y = 13'(near_y + $urandom_range(40) - 20);
                    if (r.x < 0 || r.x >= span_x) r.x = 13'($urandom_range(span_x - 1));
                    if (r.y < 0 || r.y >= span_y) r.y = 13'($urandom_range(span_y - 1));
                end else begin
                    r.x = 13'($urandom_range(span_x - 1));
                    r.y = 13'($urandom_range(span_y - 1));
                end
            end
        end
        if (r.act == ACT_READ && in_layer(r)) begin
            near_x = r.x;
            near_y = r.y;
            near_s = r.slot;
        end
        send_req(r, 1'b0, '0);
    endtask

    // Receiver side: random stalls, and every result transfer is checked
    // against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no request waiting");
                    fail_cnt = fail_cnt + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (res_ch.tile_out !== want.tile_out) begin
                        $error("tile_out: expected %h, got %h", want.tile_out, res_ch.tile_out);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (res_ch.outcome !== want.outcome) begin
                        $error("outcome: expected %0d, got %0d", want.outcome, res_ch.outcome);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (res_ch.way_used !== want.way_used) begin
                        $error("way_used: expected %0d, got %0d", want.way_used,
                               res_ch.way_used);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (res_ch.origin_x !== want.origin_x) begin
                        $error("origin_x: expected %0d, got %0d", want.origin_x,
                               res_ch.origin_x);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (res_ch.origin_y !== want.origin_y) begin
                        $error("origin_y: expected %0d, got %0d", want.origin_y,
                               res_ch.origin_y);
                        fail_cnt = fail_cnt + 1;
                    end
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge i_clk) begin
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_row row(input logic [1:0] act, input bit s, input int x, input int y,
                                 input int val, input bit typed, input logic [15:0] tile,
                                 input logic [2:0] oc);
        t_row r;
        r.req.act = act;
        r.req.slot = s;
        r.req.x = 13'(x);
        r.req.y = 13'(y);
        r.req.val = 16'(val);
        r.typed = typed;
        r.res = '0;
        r.res.tile_out = tile;
        r.res.outcome = oc;
        return r;
    endfunction

    initial begin
        t_row directed[$];
        int   near_x;
        int   near_y;
        bit   near_s;
        int   wait_cnt;
        int   sizes [6][4];

        req_ch.valid = 1'b0;
        req_ch.action = ACT_READ;
        req_ch.slot_sel = 1'b0;
        req_ch.tile_x = '0;
        req_ch.tile_y = '0;
        req_ch.tile_value = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            size_w[s] = 12'd1024;
            size_h[s] = 8'd128;
            drop_windows(s);
        end

        // The layer images start cleared in the block and in the model, so
        // every tile a refill copies holds a known word.
        for (int s = 0; s < NUM_SLOTS; s++)
            for (int i = 0; i < IMAGE_TILES; i++) begin
                image_mem[s][i] = '0;
                dut.u_store.r_img[s*IMAGE_TILES + i] = '0;
            end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Slot 0 is wider than a window so that swaps occur;
        // slot 1 is smaller than a window, so its origin clamps to zero and
        // only the part inside the layer is copied.
        set_sizes(200, 60, 3, 2);
        directed.push_back(row(ACT_READ, 0, -1, 0, 0, 1, OUTSIDE_TILE, OC_OUTSIDE));
        directed.push_back(row(ACT_READ, 0, 0, -4096, 0, 1, OUTSIDE_TILE, OC_OUTSIDE));
        directed.push_back(row(ACT_READ, 0, 4095, 4095, 0, 1, OUTSIDE_TILE, OC_OUTSIDE));
        directed.push_back(row(ACT_READ, 1, 3, 0, 0, 1, OUTSIDE_TILE, OC_OUTSIDE));
        directed.push_back(row(ACT_WRITE, 0, 200, 0, 16'h1234, 1, 16'h0, OC_IGNORED));
        directed.push_back(row(ACT_WRITE, 1, -4096, 1, 16'hFFFF, 1, 16'h0, OC_IGNORED));
        directed.push_back(row(ACT_INVAL, 1, 0, 0, 0, 1, 16'h0, OC_INVAL));
        directed.push_back(row(ACT_WRITE, 0, 0, 0, 16'hFFFF, 0, 16'h0, OC_HIT));
        directed.push_back(row(ACT_READ, 0, 0, 0, 0, 0, 16'h0, OC_HIT));
        directed.push_back(row(ACT_READ, 0, 5, 5, 0, 0, 16'h0, OC_HIT));
        directed.push_back(row(ACT_READ, 0, 199, 59, 0, 0, 16'h0, OC_HIT));
        directed.push_back(row(ACT_READ, 0, 0, 0, 0, 0, 16'h0, OC_HIT));
        directed.push_back(row(ACT_WRITE, 0, 199, 59, 16'h0000, 0, 16'h0, OC_HIT));
        directed.push_back(row(ACT_READ, 0, 199, 59, 0, 0, 16'h0, OC_HIT));
        directed.push_back(row(ACT_READ, 0, 100, 30, 0, 0, 16'h0, OC_HIT));
        directed.push_back(row(2'd3, 0, 1, 1, 16'hAAAA, 0, 16'h0, OC_HIT));
        directed.push_back(row(ACT_READ, 1, 0, 0, 0, 0, 16'h0, OC_HIT));
        directed.push_back(row(ACT_WRITE, 1, 2, 1, 16'h8001, 0, 16'h0, OC_HIT));
        directed.push_back(row(ACT_READ, 1, 2, 1, 0, 0, 16'h0, OC_HIT));
        directed.push_back(row(ACT_INVAL, 0, 0, 0, 0, 0, 16'h0, OC_HIT));
        directed.push_back(row(ACT_READ, 0, 150, 50, 0, 0, 16'h0, OC_HIT));
        directed.push_back(row(ACT_INVAL, 0, 0, 0, 0, 1, 16'h0, OC_INVAL));
        foreach (directed[i])
            send_req(directed[i].req, directed[i].typed, directed[i].res);

        // Random part over several layer sizes and idling patterns. The
        // extremes include zero sizes and oversized registers, which clamp.
        sizes = '{'{16, 8, 3, 2}, '{70, 40, 1, 128}, '{4095, 2, 5, 1},
                  '{4095, 255, 0, 7}, '{100, 50, 64, 32}, '{0, 0, 2048, 3}};
        near_x = 0;
        near_y = 0;
        near_s = 1'b0;
        for (int p = 0; p < 8; p++) begin
            set_sizes(sizes[p%6][0], sizes[p%6][1], sizes[p%6][2], sizes[p%6][3]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            for (int n = 0; n < 140; n++)
                random_req(near_x, near_y, near_s);
        end
        req_ch.valid <= 1'b0;

        // Drain, then leave room for a stray extra result to show up.
        wait_cnt = 0;
        while (pending_results.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (100) @(posedge i_clk);
        if (pending_results.size() != 0)
            $error("%0d results never arrived", pending_results.size());
        if (fail_cnt == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
